// ===== hdl/cpgwpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpgwpe_pkg
// Shared types and constants of the CpG window pattern extractor.
// ----------------------------------------------------------------------------
package cpgwpe_pkg;

    localparam logic [7:0]  CHAR_UNMETH        = 8'h7A;   // 'z'
    localparam logic [7:0]  CHAR_METH          = 8'h5A;   // 'Z'
    localparam logic [15:0] MAX_DISTANCE_RESET = 16'd100;
    localparam logic [15:0] OFFSET_MAX         = 16'hFFFF;
    localparam int          WINDOW_CPGS_DEFAULT = 4;
    localparam int          QUEUE_DEPTH_DEFAULT = 4;
    localparam int          PATTERN_W          = 4;

    // one CpG call handed from the front end to the window logic
    typedef struct packed {
        logic [31:0] pos;
        logic        meth;
        logic        new_read;
        logic        strand;
    } cpg_rec_t;

endpackage

// ===== hdl/cpg_window_pattern_extractor_core.sv =====
// ----------------------------------------------------------------------------
// cpg_window_pattern_extractor_core
// Usage: one methylation call character per input transaction (in_valid /
// in_stall); reverse-strand reads arrive already reversed. first_of_read
// marks the first character of a read and carries its start position and
// strand. 'z' and 'Z' are CpG calls; each call that completes a window of
// WINDOW_CPGS calls within max_distance yields one output transaction
// (out_valid / out_stall) with the window positions, span, 4-bit pattern
// and strand. The user writes max_distance through cfg_valid / cfg_ready
// only while idle; the block does not enforce this. cfg_ready is always high.
// Throughput is one character per cycle while in_stall is low. A CpG call is written into the
// queue at its acceptance edge and reaches the output register at the next
// edge when nothing stalls, through the window shift and span compare.
// A stalled output holds its transaction; the queue between front end and
// window logic fills and then in_stall rises. Reset clears the read state,
// the window, the queue and restores max_distance to 100.
// ----------------------------------------------------------------------------
module cpg_window_pattern_extractor_core #(
    parameter int WINDOW_CPGS = cpgwpe_pkg::WINDOW_CPGS_DEFAULT,
    parameter int QUEUE_DEPTH = cpgwpe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] max_distance,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  call_char,
    input  logic        first_of_read,
    input  logic [31:0] read_position,
    input  logic        reverse_strand,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] first_pos,
    output logic [31:0] second_pos,
    output logic [31:0] third_pos,
    output logic [31:0] last_pos,
    output logic [15:0] span,
    output logic [3:0]  pattern,
    output logic        strand_minus
);

    logic [15:0]          max_dist_reg;
    logic                 push;
    logic                 push_ready;
    cpgwpe_pkg::cpg_rec_t push_data;
    logic                 pop;
    logic                 pop_valid;
    cpgwpe_pkg::cpg_rec_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= cpgwpe_pkg::MAX_DISTANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_dist_reg <= max_distance;
        end
    end

    cpgwpe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .call_char      (call_char),
        .first_of_read  (first_of_read),
        .read_position  (read_position),
        .reverse_strand (reverse_strand),
        .push           (push),
        .push_data      (push_data),
        .push_ready     (push_ready)
    );

    cpgwpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    cpgwpe_back #(
        .WINDOW_CPGS (WINDOW_CPGS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_distance (max_dist_reg),
        .pop_valid    (pop_valid),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .first_pos    (first_pos),
        .second_pos   (second_pos),
        .third_pos    (third_pos),
        .last_pos     (last_pos),
        .span         (span),
        .pattern      (pattern),
        .strand_minus (strand_minus)
    );

`ifndef SYNTH
    a_span_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> span <= max_dist_reg)
        else $error("window span above configured limit");
`endif

endmodule

// ===== hdl/cpgwpe_queue.sv =====
// ----------------------------------------------------------------------------
// cpgwpe_queue
// Small register queue between the front end and the window logic.
// ----------------------------------------------------------------------------
module cpgwpe_queue #(
    parameter int DEPTH = cpgwpe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cpgwpe_pkg::cpg_rec_t push_data,
    output logic                 push_ready,
    input  logic                 pop,
    output logic                 pop_valid,
    output cpgwpe_pkg::cpg_rec_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cpgwpe_pkg::cpg_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[head_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("queue written while full");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");
`endif

endmodule

// ===== hdl/cpgwpe_front.sv =====
// ----------------------------------------------------------------------------
// cpgwpe_front
// Accepts call characters, tracks read offset and base, and queues CpG calls.
// ----------------------------------------------------------------------------
module cpgwpe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           call_char,
    input  logic                 first_of_read,
    input  logic [31:0]          read_position,
    input  logic                 reverse_strand,
    output logic                 push,
    output cpgwpe_pkg::cpg_rec_t push_data,
    input  logic                 push_ready
);

    logic [15:0] offset_reg;
    logic [15:0] offset_next;
    logic [31:0] base_reg;
    logic [31:0] base_next;
    logic        strand_reg;
    logic        strand_next;
    logic        pending_reg;
    logic        pending_next;
    logic        accept;
    logic        is_cpg;
    logic [15:0] offset_eff;

    assign in_stall = !push_ready;
    assign accept   = in_valid && !in_stall;
    assign is_cpg   = (call_char == cpgwpe_pkg::CHAR_UNMETH) ||
                      (call_char == cpgwpe_pkg::CHAR_METH);
    assign push     = accept && is_cpg;

    always_comb
    begin
        base_next    = first_of_read ? read_position : base_reg;
        strand_next  = first_of_read ? reverse_strand : strand_reg;
        offset_eff   = first_of_read ? '0 : offset_reg;
        offset_next  = (offset_eff == cpgwpe_pkg::OFFSET_MAX) ? offset_eff
                                                              : offset_eff + 1'b1;
        // a read start is remembered until the next cpg carries it to the window
        pending_next = push ? 1'b0 : (pending_reg || first_of_read);

        push_data.pos      = base_next + {16'b0, offset_eff} + 32'd1;
        push_data.meth     = (call_char == cpgwpe_pkg::CHAR_METH);
        push_data.new_read = pending_reg || first_of_read;
        push_data.strand   = strand_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            base_reg    <= '0;
            strand_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            offset_reg  <= offset_next;
            base_reg    <= base_next;
            strand_reg  <= strand_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== hdl/cpgwpe_back.sv =====
// ----------------------------------------------------------------------------
// cpgwpe_back
// Shifts CpG calls into the window, checks the span and drives the result.
// ----------------------------------------------------------------------------
module cpgwpe_back #(
    parameter int WINDOW_CPGS = cpgwpe_pkg::WINDOW_CPGS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          max_distance,
    input  logic                 pop_valid,
    input  cpgwpe_pkg::cpg_rec_t pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [31:0]          first_pos,
    output logic [31:0]          second_pos,
    output logic [31:0]          third_pos,
    output logic [31:0]          last_pos,
    output logic [15:0]          span,
    output logic [3:0]           pattern,
    output logic                 strand_minus
);

    localparam int SEEN_W = $clog2(WINDOW_CPGS + 1);

    logic [31:0]       pos_reg  [WINDOW_CPGS];
    logic [31:0]       pos_next [WINDOW_CPGS];
    logic              bit_reg  [WINDOW_CPGS];
    logic              bit_next [WINDOW_CPGS];
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [31:0]       span_full;
    logic [3:0]        pat_next;
    logic              emit;
    logic              out_free;

    logic              out_valid_reg;
    logic [31:0]       first_reg;
    logic [31:0]       second_reg;
    logic [31:0]       third_reg;
    logic [31:0]       last_reg;
    logic [15:0]       span_reg;
    logic [3:0]        pattern_reg;
    logic              strand_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = pop_valid && out_free;

    always_comb
    begin
        pos_next[0] = pop_data.pos;
        bit_next[0] = pop_data.meth;
        for (int i = 1; i < WINDOW_CPGS; i++)
        begin
            pos_next[i] = pop_data.new_read ? '0 : pos_reg[i-1];
            bit_next[i] = pop_data.new_read ? 1'b0 : bit_reg[i-1];
        end
        if (pop_data.new_read)
        begin
            seen_next = SEEN_W'(1);
        end
        else if (seen_reg == SEEN_W'(WINDOW_CPGS))
        begin
            seen_next = seen_reg;
        end
        else
        begin
            seen_next = seen_reg + 1'b1;
        end
        // the difference is taken modulo 2^32, so a window that wraps past the top still gets a small span
        span_full = pos_next[0] - pos_next[WINDOW_CPGS-1];
        emit      = (seen_next == SEEN_W'(WINDOW_CPGS)) &&
                    (span_full <= {16'b0, max_distance});
    end

    // newest four calls, oldest in the high bit
    genvar j;
    generate
        for (j = 0; j < cpgwpe_pkg::PATTERN_W; j++)
        begin : g_pat
            if (j < WINDOW_CPGS)
            begin : g_bit
                assign pat_next[j] = bit_next[j];
            end
            else
            begin : g_zero
                assign pat_next[j] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_CPGS; i++)
            begin
                pos_reg[i] <= '0;
                bit_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (pop)
            begin
                seen_reg <= seen_next;
                for (int i = 0; i < WINDOW_CPGS; i++)
                begin
                    pos_reg[i] <= pos_next[i];
                    bit_reg[i] <= bit_next[i];
                end
            end
            if (out_free)
            begin
                out_valid_reg <= pop && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && out_free)
        begin
            first_reg   <= pos_next[WINDOW_CPGS-1];
            second_reg  <= pos_next[WINDOW_CPGS-2];
            third_reg   <= pos_next[1];
            last_reg    <= pos_next[0];
            span_reg    <= span_full[15:0];
            pattern_reg <= pat_next;
            strand_reg  <= pop_data.strand;
        end
    end

    assign out_valid    = out_valid_reg;
    assign first_pos    = first_reg;
    assign second_pos   = second_reg;
    assign third_pos    = third_reg;
    assign last_pos     = last_reg;
    assign span         = span_reg;
    assign pattern      = pattern_reg;
    assign strand_minus = strand_reg;

`ifndef SYNTH
    a_new_read_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_data.new_read) |=> seen_reg == SEEN_W'(1))
        else $error("window not restarted at read start");

    a_span_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg - first_reg) == {16'b0, span_reg})
        else $error("span does not match window ends");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CpG window pattern extractor core. A scoreboard
// class predicts the window of the last four CpG calls of each read, with the
// offset counter, the start-position wrap and the span limit, and checks every
// output transaction field by field in order. Directed reads come first, then
// random reads and noise under three idling mixes and several span limits.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SITES       = cpgwpe_pkg::WINDOW_CPGS_DEFAULT;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef struct {
        logic [31:0] first_pos;
        logic [31:0] second_pos;
        logic [31:0] third_pos;
        logic [31:0] last_pos;
        logic [15:0] span;
        logic [3:0]  pattern;
        logic        strand_minus;
    } window_t;

    class window_scoreboard;
        logic [15:0] max_span;
        logic [15:0] offset;
        logic [31:0] base;
        logic        minus;
        int          seen;
        logic [31:0] site_pos [SITES];
        logic        site_meth [SITES];
        window_t     window_q [$];
        int          errors;

        function new();
            max_span = cpgwpe_pkg::MAX_DISTANCE_RESET;
            offset   = '0;
            base     = '0;
            minus    = 1'b0;
            errors   = 0;
            clear_sites();
        endfunction

        function void clear_sites();
            seen = 0;
            foreach (site_pos[i])
            begin
                site_pos[i]  = '0;
                site_meth[i] = 1'b0;
            end
        endfunction

        // one accepted call character; queues the window it completes, if any
        function void note_char(logic [7:0] ch, logic first, logic [31:0] pos, logic rev);
            logic [31:0] here;
            logic [31:0] width;
            logic [3:0]  bits;
            window_t     w;
            if (first)
            begin
                base   = pos;
                minus  = rev;
                offset = '0;
                clear_sites();
            end
            here = base + {16'd0, offset} + 32'd1;
            if (offset != cpgwpe_pkg::OFFSET_MAX)
                offset++;
            if (ch != cpgwpe_pkg::CHAR_UNMETH && ch != cpgwpe_pkg::CHAR_METH)
                return;
            for (int i = SITES - 1; i > 0; i--)
            begin
                site_pos[i]  = site_pos[i-1];
                site_meth[i] = site_meth[i-1];
            end
            site_pos[0]  = here;
            site_meth[0] = (ch == cpgwpe_pkg::CHAR_METH);
            if (seen < SITES)
                seen++;
            if (seen < SITES)
                return;
            width = site_pos[0] - site_pos[SITES-1];
            if (width > {16'd0, max_span})
                return;
            bits = '0;
            for (int i = SITES - 1; i >= 0; i--)
                bits = {bits[2:0], site_meth[i]};
            w.first_pos    = site_pos[SITES-1];
            w.second_pos   = site_pos[SITES-2];
            w.third_pos    = site_pos[1];
            w.last_pos     = site_pos[0];
            w.span         = width[15:0];
            w.pattern      = bits;
            w.strand_minus = minus;
            window_q = {window_q, w};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        endtask

        task check_window(window_t got);
            window_t want;
            if (window_q.size() == 0)
            begin
                report("unexpected transaction, last_pos", got.last_pos, 32'd0);
                return;
            end
            want = window_q.pop_front();
            if (got.first_pos !== want.first_pos)
                report("first_pos", got.first_pos, want.first_pos);
            if (got.second_pos !== want.second_pos)
                report("second_pos", got.second_pos, want.second_pos);
            if (got.third_pos !== want.third_pos)
                report("third_pos", got.third_pos, want.third_pos);
            if (got.last_pos !== want.last_pos)
                report("last_pos", got.last_pos, want.last_pos);
            if (got.span !== want.span)
                report("span", {16'd0, got.span}, {16'd0, want.span});
            if (got.pattern !== want.pattern)
                report("pattern", {28'd0, got.pattern}, {28'd0, want.pattern});
            if (got.strand_minus !== want.strand_minus)
                report("strand_minus", {31'd0, got.strand_minus},
                       {31'd0, want.strand_minus});
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] max_distance = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  call_char = '0;
    logic        first_of_read = 1'b0;
    logic [31:0] read_position = '0;
    logic        reverse_strand = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] first_pos;
    logic [31:0] second_pos;
    logic [31:0] third_pos;
    logic [31:0] last_pos;
    logic [15:0] span;
    logic [3:0]  pattern;
    logic        strand_minus;

    window_scoreboard sb;
    int               in_idle_pct;
    int               out_stall_pct;
    int               quiet_cycles = 0;

    cpg_window_pattern_extractor_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_distance   (max_distance),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .call_char      (call_char),
        .first_of_read  (first_of_read),
        .read_position  (read_position),
        .reverse_strand (reverse_strand),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .first_pos      (first_pos),
        .second_pos     (second_pos),
        .third_pos      (third_pos),
        .last_pos       (last_pos),
        .span           (span),
        .pattern        (pattern),
        .strand_minus   (strand_minus)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    // monitors see pre-edge values, so acceptance is judged as the block sees it
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_char(call_char, first_of_read, read_position, reverse_strand);
    end

    always @(posedge clk)
    begin
        window_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            w.first_pos    = first_pos;
            w.second_pos   = second_pos;
            w.third_pos    = third_pos;
            w.last_pos     = last_pos;
            w.span         = span;
            w.pattern      = pattern;
            w.strand_minus = strand_minus;
            sb.check_window(w);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_char(input logic [7:0] ch, input logic first, input logic [31:0] pos,
                             input logic rev);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        call_char      <= ch;
        first_of_read  <= first;
        read_position  <= pos;
        reverse_strand <= rev;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [7:0] pick_char(int density);
        if ($urandom_range(99) < density)
            return $urandom_range(1) ? cpgwpe_pkg::CHAR_METH : cpgwpe_pkg::CHAR_UNMETH;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_read(input int chars);
        logic [31:0] start;
        logic        rev;
        int          density;
        start   = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(40) : $urandom;
        rev     = 1'($urandom_range(1));
        density = $urandom_range(15, 75);
        for (int k = 0; k < chars; k++)
            send_char(pick_char(density), k == 0, (k == 0) ? start : $urandom,
                      (k == 0) ? rev : 1'($urandom_range(1)));
    endtask

    // mostly well-formed reads of random length, some stray characters
    task automatic send_mix(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(1, 40);
                send_read(len);
                sent += len;
            end
            else
            begin
                send_char(8'($urandom_range(255)), $urandom_range(19) == 0, $urandom,
                          1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.window_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_distance(input logic [15:0] value);
        wait_idle();
        cfg_valid    <= 1'b1;
        max_distance <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.max_span = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // no read started yet: base 0, forward strand
        send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b0, 32'hFFFF_FFFF, 1'b1);
        send_char(8'h00, 1'b0, 32'h0, 1'b0);
        send_char(cpgwpe_pkg::CHAR_METH, 1'b0, 32'h0, 1'b1);
        send_char(8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b0, 32'h0, 1'b0);
        send_char(cpgwpe_pkg::CHAR_METH, 1'b0, 32'h0, 1'b0);
        // reverse read whose positions wrap past the top of the address range
        send_char(cpgwpe_pkg::CHAR_METH, 1'b1, 32'hFFFF_FFFD, 1'b1);
        repeat (3) send_char(cpgwpe_pkg::CHAR_METH, 1'b0, 32'h0, 1'b0);
        send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b0, 32'h0, 1'b0);
        // start at the largest position
        send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b1, 32'hFFFF_FFFF, 1'b0);
        repeat (3) send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b0, 32'h0, 1'b1);
        // a new read cuts a partial window short
        send_char(cpgwpe_pkg::CHAR_METH, 1'b1, 32'h0, 1'b0);
        send_char(cpgwpe_pkg::CHAR_METH, 1'b0, 32'h0, 1'b0);
        send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b1, 32'h0000_1000, 1'b1);
        send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b0, 32'h0, 1'b0);
        send_char(cpgwpe_pkg::CHAR_UNMETH, 1'b0, 32'h0, 1'b0);
        send_char(cpgwpe_pkg::CHAR_METH, 1'b0, 32'h0, 1'b0);
    endtask

    initial
    begin
        sb            = new();
        in_idle_pct   = 13;
        out_stall_pct = 55;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        set_distance(16'hFFFF);
        send_mix(140);
        set_distance(16'd0);
        send_mix(100);
        set_distance(16'($urandom_range(5, 300)));
        send_mix(170);

        in_idle_pct   = 55;
        out_stall_pct = 13;
        set_distance(16'd20);
        send_mix(220);
        set_distance(16'($urandom_range(65535)));
        send_mix(90);
        set_distance(16'd60);
        send_mix(130);

        in_idle_pct   = 0;
        out_stall_pct = 0;
        set_distance(16'd0);
        send_mix(90);
        set_distance(16'hFFFF);
        send_mix(220);
        set_distance(16'd12);
        send_mix(170);

        wait_idle();
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
